### rtl/tcc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tcc_pkg
// Shared sizes, character codes and command types of the text console.
// ============================================================================
package tcc_pkg;

    // buffer geometry
    localparam int ROWS = 29;
    localparam int COLS = 71;

    // field widths of the request and result channels
    localparam int CHAR_W      = 8;
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;

    // internal widths
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W     = $clog2(COLS);
    localparam int CY_W      = $clog2(ROWS + 2);
    localparam int LEN_W     = $clog2(COLS + 1);
    localparam int RAM_DEPTH = ROWS * (2 ** COL_W);
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int TAB_W     = 3;

    // command queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // opcodes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_NUL        = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB        = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_REPLACE    = 8'h3F;
    localparam logic [CHAR_W-1:0] CHAR_LAST_PRINT = 8'h7E;

    typedef enum logic [2:0] {
        CMD_READ,
        CMD_SKIP,
        CMD_TAB,
        CMD_NEWLINE,
        CMD_CHAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [CHAR_W-1:0]       ch;
        logic [ROW_FIELD_W-1:0]  row;
        logic [COL_FIELD_W-1:0]  col;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_flags_t;

endpackage

### rtl/tcc_req_if.sv
`timescale 1ns / 1ps
// ============================================================================
// tcc_req_if
// Request channel: append or read, with valid/ready handshake.
// ============================================================================
interface tcc_req_if;
    import tcc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [CHAR_W-1:0]      char_code;
    logic [ROW_FIELD_W-1:0] read_row;
    logic [COL_FIELD_W-1:0] read_col;

    modport source (output valid, output opcode, output char_code, output read_row,
                    output read_col, input ready);
    modport sink   (input valid, input opcode, input char_code, input read_row,
                    input read_col, output ready);
endinterface

### rtl/tcc_rsp_if.sv
`timescale 1ns / 1ps
// ============================================================================
// tcc_rsp_if
// Result channel: read cell and cursor position, with valid/ready handshake.
// ============================================================================
interface tcc_rsp_if;
    import tcc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CHAR_W-1:0]      cell_char;
    logic [COL_FIELD_W-1:0] cursor_col;
    logic [ROW_FIELD_W-1:0] cursor_row;

    modport source (output valid, output cell_char, output cursor_col, output cursor_row,
                    input ready);
    modport sink   (input valid, input cell_char, input cursor_col, input cursor_row,
                    output ready);
endinterface

### rtl/tcc_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// tcc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ============================================================================
module tcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/tcc_front.sv
`timescale 1ns / 1ps
// ============================================================================
// tcc_front
// Takes requests while the queue has room and sorts them into commands.
// ============================================================================
module tcc_front (
    tcc_req_if.sink           request,
    input  tcc_pkg::q_flags_t q_flags,
    output logic              push,
    output tcc_pkg::cmd_t     cmd
);
    import tcc_pkg::*;

    assign request.ready = !q_flags.full;
    assign push          = request.valid && !q_flags.full;

    always_comb
    begin
        cmd.row  = request.read_row;
        cmd.col  = request.read_col;
        cmd.ch   = request.char_code;
        cmd.kind = CMD_CHAR;
        if (request.opcode == OP_READ)
        begin
            cmd.kind = CMD_READ;
        end
        else
        begin
            unique case (request.char_code)
                CHAR_NUL:     cmd.kind = CMD_SKIP;
                CHAR_TAB:
                begin
                    cmd.kind = CMD_TAB;
                    cmd.ch   = CHAR_SPACE;
                end
                CHAR_NEWLINE: cmd.kind = CMD_NEWLINE;
                default:
                begin
                    // control codes and anything past tilde show as '?'
                    cmd.kind = CMD_CHAR;
                    if (request.char_code < CHAR_SPACE || request.char_code > CHAR_LAST_PRINT)
                    begin
                        cmd.ch = CHAR_REPLACE;
                    end
                end
            endcase
        end
    end

endmodule

### rtl/tcc_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// tcc_queue
// Short command queue between the front and back ends.
// ============================================================================
module tcc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tcc_pkg::cmd_t     wdata,
    input  logic              pop,
    output tcc_pkg::cmd_t     head,
    output tcc_pkg::q_flags_t flags
);
    import tcc_pkg::*;

    cmd_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_CNT_W-1:0] count_reg,  count_next;

    assign head        = slot_reg[rd_ptr_reg];
    assign flags.empty = (count_reg == '0);
    assign flags.full  = (count_reg == Q_CNT_W'(Q_DEPTH));

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### rtl/tcc_back.sv
`timescale 1ns / 1ps
// ============================================================================
// tcc_back
// Carries out commands: cell writes, reads, cursor moves and scrolling.
// ============================================================================
module tcc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  tcc_pkg::cmd_t     head,
    input  tcc_pkg::q_flags_t q_flags,
    output logic              pop,
    tcc_rsp_if.source         response
);
    import tcc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PUT    = 2'd1;
    localparam logic [1:0] ST_SETTLE = 2'd2;
    localparam logic [1:0] ST_READ   = 2'd3;

    logic [1:0]             state_reg,     state_next;
    cmd_t                   cmd_reg,       cmd_next;
    logic [COL_W-1:0]       x_reg,         x_next;
    logic [CY_W-1:0]        y_reg,         y_next;
    logic [ROW_W-1:0]       top_reg,       top_next;
    logic [LEN_W-1:0]       len_reg [ROWS];
    logic [LEN_W-1:0]       len_next [ROWS];
    logic                   hit_reg,       hit_next;
    logic                   res_valid_reg, res_valid_next;
    logic [CHAR_W-1:0]      res_cell_reg,  res_cell_next;
    logic [COL_FIELD_W-1:0] res_col_reg,   res_col_next;
    logic [ROW_FIELD_W-1:0] res_row_reg,   res_row_next;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [CHAR_W-1:0]      ram_rdata;

    logic                   rd_in_range;
    logic [ROW_W-1:0]       rd_phys;
    logic [ROW_W-1:0]       cur_phys;
    logic                   done;

    // logical line to physical line of the circular row store
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lr,
                                                  input logic [ROW_W-1:0] tp);
        logic [ROW_W:0] sum;
        sum = {1'b0, lr} + {1'b0, tp};
        if (sum >= (ROW_W + 1)'(ROWS))
        begin
            sum = sum - (ROW_W + 1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    tcc_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (RAM_DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd_reg.ch),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_in_range = (32'(head.row) < ROWS) && (32'(head.col) < COLS);
    assign rd_phys     = phys_row(rd_in_range ? ROW_W'(head.row) : '0, top_reg);
    assign cur_phys    = phys_row(ROW_W'(y_reg), top_reg);
    assign ram_raddr   = {rd_phys, COL_W'(head.col)};

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        top_next       = top_reg;
        len_next       = len_reg;
        hit_next       = hit_reg;
        res_valid_next = res_valid_reg;
        res_cell_next  = res_cell_reg;
        res_col_next   = res_col_reg;
        res_row_next   = res_row_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = {cur_phys, x_reg};
        done           = 1'b0;

        if (res_valid_reg && response.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_flags.empty && !res_valid_reg)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    unique case (head.kind) inside
                        CMD_READ:
                        begin
                            hit_next   = rd_in_range &&
                                         (32'(head.col) < 32'(len_reg[rd_phys]));
                            state_next = ST_READ;
                        end
                        CMD_TAB, CMD_CHAR:
                        begin
                            state_next = ST_PUT;
                        end
                        CMD_NEWLINE:
                        begin
                            x_next     = '0;
                            y_next     = y_reg + 1'b1;
                            state_next = ST_SETTLE;
                        end
                        default:
                        begin
                            // ignored byte: report the cursor as it is
                            done          = 1'b1;
                            res_cell_next = '0;
                        end
                    endcase
                end
            end
            ST_PUT:
            begin
                if (32'(y_reg) >= ROWS)
                begin
                    // pending scroll after a wrap on the last line
                    len_next[top_reg] = '0;
                    top_next = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
                    y_next   = y_reg - 1'b1;
                end
                else
                begin
                    ram_we             = 1'b1;
                    len_next[cur_phys] = LEN_W'(x_reg) + 1'b1;
                    if (x_reg == COL_W'(COLS - 1))
                    begin
                        x_next = '0;
                        y_next = y_reg + 1'b1;
                    end
                    else
                    begin
                        x_next = x_reg + 1'b1;
                    end
                    if (cmd_reg.kind != CMD_TAB || x_next[TAB_W-1:0] == '0)
                    begin
                        done          = 1'b1;
                        res_cell_next = '0;
                    end
                end
            end
            ST_SETTLE:
            begin
                if (32'(y_reg) >= ROWS)
                begin
                    len_next[top_reg] = '0;
                    top_next = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
                    y_next   = y_reg - 1'b1;
                end
                else
                begin
                    done          = 1'b1;
                    res_cell_next = '0;
                end
            end
            ST_READ:
            begin
                done          = 1'b1;
                res_cell_next = hit_reg ? ram_rdata : '0;
            end
        endcase

        if (done)
        begin
            res_valid_next = 1'b1;
            res_col_next   = COL_FIELD_W'(x_next);
            res_row_next   = ROW_FIELD_W'(y_next);
            state_next     = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            x_reg         <= '0;
            y_reg         <= '0;
            top_reg       <= '0;
            len_reg       <= '{default: '0};
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            top_reg       <= top_next;
            len_reg       <= len_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        hit_reg      <= hit_next;
        res_cell_reg <= res_cell_next;
        res_col_reg  <= res_col_next;
        res_row_reg  <= res_row_next;
    end

    assign response.valid      = res_valid_reg;
    assign response.cell_char  = res_cell_reg;
    assign response.cursor_col = res_col_reg;
    assign response.cursor_row = res_row_reg;

endmodule

### rtl/text_console_cursor_scroll.sv
`timescale 1ns / 1ps
// ============================================================================
// text_console_cursor_scroll
// Character console buffer with cursor, tab, newline, wrap and scroll.
// ============================================================================
// Each request gives exactly one result carrying the cursor after the request
// and, for reads, the stored cell byte. After the queue hands a command over,
// the back end skips a zero byte, reads a cell, writes a character, moves the
// cursor on a newline, or fills a tab with spaces to the next multiple of eight
// columns (one cell write per cycle through the single write port of the cell
// RAM, held while one or two lines scroll). A command starts after the previous
// result is taken. Scrolling moves a row offset instead of copying cells;
// each line keeps a count of the columns written since it was last freed,
// so freed lines read as empty at once and no clearing pass runs after reset.
// A two-deep queue lets requests be taken while a result waits.
module text_console_cursor_scroll (
    input  logic      clk,
    input  logic      rst_n,
    tcc_req_if.sink   request,
    tcc_rsp_if.source response
);
    import tcc_pkg::*;

    // front to queue
    logic     push;
    cmd_t     cmd;

    // queue to back
    cmd_t     head;
    q_flags_t q_flags;
    logic     pop;

    // accept and classify requests
    tcc_front u_front (
        .request (request),
        .q_flags (q_flags),
        .push    (push),
        .cmd     (cmd)
    );

    // decouples the request side from the command engine
    tcc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd),
        .pop   (pop),
        .head  (head),
        .flags (q_flags)
    );

    // cell store, cursor and scroll engine, result register
    tcc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_flags  (q_flags),
        .pop      (pop),
        .response (response)
    );

    // queue never overruns
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_flags.full)
        else $error("command pushed into full queue");

    // back end never takes from an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_flags.empty)
        else $error("command popped from empty queue");

    // reported cursor stays inside the buffer, one past the last line at most
    a_cursor_col: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid |-> (32'(response.cursor_col) < COLS))
        else $error("cursor column out of range");

    a_cursor_row: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid |-> (32'(response.cursor_row) <= ROWS))
        else $error("cursor row out of range");

endmodule
